// ===== rtl/core/smsm_pkg.sv =====
// Package: word types, parse phases and constants of the SMS user-data masker.
`timescale 1ns / 1ps

package smsm_pkg;

	// Input word: one byte of the SIP message with its framing
	typedef struct packed {
		logic [7:0]  message_byte;
		logic [15:0] message_length;
		logic        final_byte;
		logic        mask_request;
	} msg_word_t;

	// Result word: the byte as passed on, with flags
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_final;
		logic       was_masked;
		logic       parse_status;
	} res_word_t;

	// Parse phases
	typedef enum logic [4:0] {
		PH_SEARCH     = 5'd0,
		PH_RP_TYPE    = 5'd1,
		PH_RP_REF     = 5'd2,
		PH_OA_FIRST   = 5'd3,
		PH_OA_SKIP    = 5'd4,
		PH_DA_FIRST   = 5'd5,
		PH_DA_SKIP    = 5'd6,
		PH_RPUD_LEN   = 5'd7,
		PH_TP_FIRST   = 5'd8,
		PH_TP_MR      = 5'd9,
		PH_TP_DALEN   = 5'd10,
		PH_TP_TOA     = 5'd11,
		PH_TP_DA_SKIP = 5'd12,
		PH_TP_PID     = 5'd13,
		PH_TP_DCS     = 5'd14,
		PH_TP_VP_SKIP = 5'd15,
		PH_TP_UDL     = 5'd16,
		PH_TP_UD      = 5'd17,
		PH_DONE       = 5'd18
	} phase_t;

	// Separator characters
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;

	// TPDU field masks and codes
	localparam logic [7:0] MTI_MASK     = 8'h03;
	localparam logic [7:0] MTI_SUBMIT   = 8'h01;
	localparam logic [7:0] VPF_MASK     = 8'h18;
	localparam logic [7:0] TON_MASK     = 8'h70;
	localparam logic [7:0] TON_ALNUM    = 8'h50;
	localparam logic [7:0] LOW_NIBBLE   = 8'h0f;

	// Validity period formats
	localparam logic [1:0] VPF_NONE     = 2'd0;
	localparam logic [1:0] VPF_RELATIVE = 2'd2;

	// Packed-space fill pattern, period seven
	localparam int         FILL_LEN = 7;
	localparam logic [7:0] FILL_PATTERN [FILL_LEN] = '{
		8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h81, 8'h40
	};

endpackage

// ===== rtl/core/smsm_fill.sv =====
// Fill pattern generator: pattern byte for a user-data octet.
`timescale 1ns / 1ps

module smsm_fill (
	input  logic [2:0] idx,
	input  logic       last,
	output logic [7:0] fill
);
	import smsm_pkg::*;

	logic [7:0] pat;

	// Pattern lookup; last octet at position 5 or 6 drops its upper nibble
	always_comb begin
		pat = (idx < 3'(FILL_LEN)) ? FILL_PATTERN[idx] : 8'h00;
		if (last && idx >= 3'd5) begin
			fill = pat & LOW_NIBBLE;
		end else begin
			fill = pat;
		end
	end

endmodule

// ===== rtl/core/smsm_parser.sv =====
// Parser: per-byte RP-DATA / SMS-SUBMIT parse state and masking decision.
`timescale 1ns / 1ps

module smsm_parser #(
	parameter int MAX_MESSAGE_BYTES = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  smsm_pkg::msg_word_t item,
	output smsm_pkg::res_word_t result
);
	import smsm_pkg::*;

	localparam logic [15:0] MaxBytes = 16'(MAX_MESSAGE_BYTES);

	// Parse state
	phase_t      phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [2:0]  crlf_q, crlf_d;
	logic [7:0]  skip_q, skip_d;
	logic        dir_q, dir_d;
	logic [7:0]  tlen_q, tlen_d;
	logic [15:0] tpos_q, tpos_d;
	logic [1:0]  vpf_q, vpf_d;
	logic [7:0]  udl_q, udl_d;
	logic [7:0]  udi_q, udi_d;
	logic [2:0]  udm_q, udm_d;
	logic        status_q, status_d;

	logic [7:0]  b;
	logic [15:0] rest;
	logic        active;
	logic [2:0]  crlf_inc;
	logic [7:0]  expect_ch;
	logic [10:0] a_alnum;
	logic [8:0]  a_semi;
	logic [7:0]  a_len;
	logic [8:0]  udi_inc;
	logic        ud_last;
	logic [7:0]  fill;
	logic [7:0]  ob;
	logic        masked;

	assign b       = item.message_byte;
	assign rest    = item.message_length - pos_q;
	assign active  = (pos_q < item.message_length) && (pos_q < MaxBytes);
	assign udi_inc = {1'b0, udi_q} + 9'd1;
	assign ud_last = (udi_inc == {1'b0, udl_q});

	// Address octet counts from the TP-DA digit count
	assign a_alnum = (({3'b0, skip_q} << 3) - {3'b0, skip_q} + 11'd7) >> 3;
	assign a_semi  = ({1'b0, skip_q} + 9'd1) >> 1;
	assign a_len   = ((b & TON_MASK) == TON_ALNUM) ? a_alnum[7:0] : a_semi[7:0];

	smsm_fill u_fill (
		.idx  (udm_q),
		.last (ud_last),
		.fill (fill)
	);

	// Next parse state and output byte
	always_comb begin
		phase_d  = phase_q;
		crlf_d   = crlf_q;
		skip_d   = skip_q;
		dir_d    = dir_q;
		tlen_d   = tlen_q;
		tpos_d   = tpos_q;
		vpf_d    = vpf_q;
		udl_d    = udl_q;
		udi_d    = udi_q;
		udm_d    = udm_q;
		status_d = status_q;
		ob       = b;
		masked   = 1'b0;
		expect_ch = crlf_q[0] ? CHAR_LF : CHAR_CR;
		crlf_inc  = crlf_q + 3'd1;

		if (active) begin
			case (phase_q)
				PH_SEARCH: begin
					if (b == expect_ch) begin
						crlf_d = crlf_inc;
					end else begin
						crlf_d = (b == CHAR_CR) ? 3'd1 : 3'd0;
					end
					if (crlf_d >= 3'd4) begin
						if (rest <= 16'd1) begin
							status_d = 1'b0;
							phase_d  = PH_DONE;
						end else begin
							phase_d = PH_RP_TYPE;
						end
					end
				end
				PH_RP_TYPE: begin
					if (b > 8'd1) begin
						status_d = 1'b1;
						phase_d  = PH_DONE;
					end else begin
						dir_d   = b[0];
						phase_d = PH_RP_REF;
					end
				end
				PH_RP_REF: phase_d = PH_OA_FIRST;
				PH_OA_FIRST: begin
					if (!dir_q) begin
						if (b != 8'd0) begin
							status_d = 1'b0;
							phase_d  = PH_DONE;
						end else begin
							phase_d = PH_DA_FIRST;
						end
					end else if ({8'd0, b} >= rest) begin
						status_d = 1'b0;
						phase_d  = PH_DONE;
					end else if (b == 8'd0) begin
						phase_d = PH_DA_FIRST;
					end else begin
						skip_d  = b;
						phase_d = PH_OA_SKIP;
					end
				end
				PH_OA_SKIP: begin
					skip_d = skip_q - 8'd1;
					if (skip_d == 8'd0) phase_d = PH_DA_FIRST;
				end
				PH_DA_FIRST: begin
					if (dir_q) begin
						if (b != 8'd0) begin
							status_d = 1'b0;
							phase_d  = PH_DONE;
						end else begin
							phase_d = PH_RPUD_LEN;
						end
					end else if ({8'd0, b} >= rest) begin
						status_d = 1'b0;
						phase_d  = PH_DONE;
					end else if (b == 8'd0) begin
						phase_d = PH_RPUD_LEN;
					end else begin
						skip_d  = b;
						phase_d = PH_DA_SKIP;
					end
				end
				PH_DA_SKIP: begin
					skip_d = skip_q - 8'd1;
					if (skip_d == 8'd0) phase_d = PH_RPUD_LEN;
				end
				PH_RPUD_LEN: begin
					if ({8'd0, b} > rest) begin
						status_d = 1'b0;
						phase_d  = PH_DONE;
					end else begin
						tlen_d  = b;
						tpos_d  = 16'd0;
						phase_d = PH_TP_FIRST;
					end
				end
				PH_TP_FIRST: begin
					if ((b & MTI_MASK) != MTI_SUBMIT) begin
						status_d = 1'b1;
						phase_d  = PH_DONE;
					end else if (tlen_q < 8'd4) begin
						status_d = 1'b0;
						phase_d  = PH_DONE;
					end else begin
						vpf_d   = 2'((b & VPF_MASK) >> 3);
						phase_d = PH_TP_MR;
					end
				end
				PH_TP_MR: phase_d = PH_TP_DALEN;
				PH_TP_DALEN: begin
					skip_d  = b;
					phase_d = PH_TP_TOA;
				end
				PH_TP_TOA: begin
					if ({1'b0, a_len} + 9'd4 >= {1'b0, tlen_q}) begin
						status_d = 1'b0;
						phase_d  = PH_DONE;
					end else if (a_len == 8'd0) begin
						phase_d = PH_TP_PID;
					end else begin
						skip_d  = a_len;
						phase_d = PH_TP_DA_SKIP;
					end
				end
				PH_TP_DA_SKIP: begin
					skip_d = skip_q - 8'd1;
					if (skip_d == 8'd0) phase_d = PH_TP_PID;
				end
				PH_TP_PID: phase_d = PH_TP_DCS;
				PH_TP_DCS: begin
					if (b != 8'd0) begin
						status_d = 1'b0;
						phase_d  = PH_DONE;
					end else if (vpf_q == VPF_NONE) begin
						phase_d = PH_TP_UDL;
					end else begin
						// relative period is one octet, the other two are seven
						skip_d  = (vpf_q == VPF_RELATIVE) ? 8'd1 : 8'd7;
						phase_d = PH_TP_VP_SKIP;
					end
				end
				PH_TP_VP_SKIP: begin
					skip_d = skip_q - 8'd1;
					if (skip_d == 8'd0) phase_d = PH_TP_UDL;
				end
				PH_TP_UDL: begin
					if ({1'b0, tpos_q} + 17'd1 >= {9'd0, tlen_q}) begin
						status_d = 1'b0;
						phase_d  = PH_DONE;
					end else begin
						udl_d    = b;
						udi_d    = 8'd0;
						udm_d    = 3'd0;
						status_d = 1'b1;
						phase_d  = (b == 8'd0) ? PH_DONE : PH_TP_UD;
					end
				end
				PH_TP_UD: begin
					if (item.mask_request) begin
						ob     = fill;
						masked = 1'b1;
					end
					udi_d = udi_inc[7:0];
					udm_d = (udm_q == 3'd6) ? 3'd0 : udm_q + 3'd1;
					if (udi_inc >= {1'b0, udl_q} ||
					    {1'b0, tpos_q} + 17'd1 >= {9'd0, tlen_q}) begin
						phase_d = PH_DONE;
					end
				end
				PH_DONE: phase_d = PH_DONE;
				default: phase_d = PH_DONE;
			endcase

			// TPDU octet counter
			if (phase_q >= PH_TP_MR && phase_q < PH_DONE && tpos_q != 16'hffff) begin
				tpos_d = tpos_q + 16'd1;
			end else if (phase_q == PH_TP_FIRST) begin
				tpos_d = 16'd1;
			end
		end
	end

	// Saturating byte counter
	assign pos_d = (pos_q != 16'hffff) ? pos_q + 16'd1 : pos_q;

	// Result word
	always_comb begin
		result.out_byte     = ob;
		result.out_final    = item.final_byte;
		result.was_masked   = masked;
		result.parse_status = item.final_byte & status_d;
	end

	// State registers; cleared after the last byte of a message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			pos_q    <= '0;
			crlf_q   <= '0;
			skip_q   <= '0;
			dir_q    <= 1'b0;
			tlen_q   <= '0;
			tpos_q   <= '0;
			vpf_q    <= '0;
			udl_q    <= '0;
			udi_q    <= '0;
			udm_q    <= '0;
			status_q <= 1'b0;
		end else if (step) begin
			if (item.final_byte) begin
				phase_q  <= PH_SEARCH;
				pos_q    <= '0;
				crlf_q   <= '0;
				skip_q   <= '0;
				dir_q    <= 1'b0;
				tlen_q   <= '0;
				tpos_q   <= '0;
				vpf_q    <= '0;
				udl_q    <= '0;
				udi_q    <= '0;
				udm_q    <= '0;
				status_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				crlf_q   <= crlf_d;
				skip_q   <= skip_d;
				dir_q    <= dir_d;
				tlen_q   <= tlen_d;
				tpos_q   <= tpos_d;
				vpf_q    <= vpf_d;
				udl_q    <= udl_d;
				udi_q    <= udi_d;
				udm_q    <= udm_d;
				status_q <= status_d;
			end
		end
	end

endmodule

// ===== rtl/core/sms_rp_tpdu_user_data_masker_top.sv =====
// Top level: input register, parser and result register of the SMS user-data masker.
`timescale 1ns / 1ps
//
// Takes a SIP message one byte per word on the msg channel (valid/ready) and
// returns every byte on the res channel (valid/ready), either unchanged or,
// when mask_request is set and the byte is SMS-SUBMIT user data, replaced by
// the packed-space fill pattern. final_byte marks the last byte of a message;
// parse_status is meaningful on that word only, 0 elsewhere.
// A result word moves from the input register to the result register when
// that register is empty or its word is being taken, and is offered from
// there until the receiver takes it.
// Throughput: one byte per cycle while the receiver takes results; the parse
// is a single pass of compares and counters between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; msg_ready drops only when both are
// full and the result is not taken.
// Reset clears both register valids and returns the parser to its search for
// the header/body separator. After each final byte the parser also returns to
// that state for the next message.
//
module sms_rp_tpdu_user_data_masker_top #(
	parameter int MAX_MESSAGE_BYTES = 65535
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_ready,
	input  smsm_pkg::msg_word_t msg,
	output logic                res_valid,
	input  logic                res_ready,
	output smsm_pkg::res_word_t res
);
	import smsm_pkg::*;

	logic      s1_valid_q;
	msg_word_t item_s1;
	logic      res_valid_q;
	res_word_t res_s2;
	res_word_t result;
	logic      advance;

	// Move the registered byte through the parser when the result slot frees
	assign advance   = s1_valid_q && (!res_valid_q || res_ready);
	assign msg_ready = !s1_valid_q || advance;
	assign res_valid = res_valid_q;
	assign res       = res_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (msg_ready) begin
			s1_valid_q <= msg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_ready && msg_valid) begin
			item_s1 <= msg;
		end
	end

	smsm_parser #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

`ifndef ASSERT_OFF
	// An empty result slot never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> msg_ready)
		else $error("msg_ready low while result register empty");

	// A byte that can move on shows up as a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && (!res_valid_q || res_ready) |=> res_valid_q)
		else $error("parsed word did not reach the result register");

	// Status is reported on the final byte only
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_s2.out_final |-> !res_s2.parse_status)
		else $error("parse_status set on a non-final byte");
`endif

endmodule
